// ----- hw/rtl/psn_pkg.sv -----
`timescale 1ns / 1ps

package psn_pkg;

   localparam int CoordW = 32;   // coordinate width, two's complement
   localparam int DistW  = 34;   // distance width, unsigned
   localparam int DeltaW = 33;   // difference of two coordinates
   localparam int ProdW  = 66;   // product of two differences
   localparam int DotW   = 67;   // sum of two products, signed
   localparam int LenW   = 65;   // squared length, unsigned
   localparam int SplitW = 33;   // low slice of the dot product for the multipliers
   localparam int NumW   = 97;   // rounded numerator of the foot offset
   localparam int QBits  = 32;   // quotient bits of the foot offset
   localparam int RBits  = 33;   // root bits of the distance
   localparam int RemW   = 65;   // root remainder
   localparam int TrialW = 67;   // root trial subtrahend

   typedef enum logic [1:0] {
      CSR_START_X = 2'd0,
      CSR_START_Y = 2'd1,
      CSR_END_X   = 2'd2,
      CSR_END_Y   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      SEL_START = 3'b001,
      SEL_END   = 3'b010,
      SEL_FOOT  = 3'b100
   } sel_type;

   typedef struct packed {
      logic [CoordW-1:0] start_x;
      logic [CoordW-1:0] start_y;
      logic [CoordW-1:0] end_x;
      logic [CoordW-1:0] end_y;
   } cfg_type;

   typedef struct packed {
      logic [CoordW-1:0] px;
      logic [CoordW-1:0] py;
      logic [DistW-1:0]  best;
      sel_type           sel;
      logic              sgnx;
      logic              sgny;
      logic [CoordW-1:0] mx;
      logic [CoordW-1:0] my;
      logic [LenW-1:0]   dot;
      logic [LenW-1:0]   len;
   } q_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ----- hw/rtl/psn_front.sv -----
`timescale 1ns / 1ps

module psn_front import psn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CoordW-1:0] req_point_x,
   input  logic [CoordW-1:0] req_point_y,
   input  logic [DistW-1:0]  req_best_in,
   input  q_stat_type        q_stat,
   output logic              q_push,
   output q_type             q_entry
);

   logic fe;

   logic              f1_vld_ff, f2_vld_ff, f3_vld_ff, f4_vld_ff;
   logic [CoordW-1:0] f1_px_ff, f1_py_ff, f2_px_ff, f2_py_ff, f3_px_ff, f3_py_ff;
   logic [DistW-1:0]  f1_best_ff, f2_best_ff, f3_best_ff;
   logic [DeltaW-1:0] f1_ex_ff, f1_ey_ff, f1_dx_ff, f1_dy_ff;
   logic [DeltaW-1:0] f2_dx_ff, f2_dy_ff, f3_dx_ff, f3_dy_ff;
   logic [DeltaW-1:0] f1_ex_in, f1_ey_in, f1_dx_in, f1_dy_in;
   logic signed [ProdW-1:0] f2_pex_in, f2_pey_in, f2_pdx_in, f2_pdy_in;
   logic signed [ProdW-1:0] f2_pex_ff, f2_pey_ff, f2_pdx_ff, f2_pdy_ff;
   logic [DotW-1:0]   f3_dot_in, f3_dot_ff;
   logic [LenW-1:0]   f3_len_in, f3_len_ff;
   logic [DeltaW-1:0] f4_mx_full, f4_my_full;
   q_type             f4_q_in, f4_q_ff;

   // freeze the whole front while its last stage cannot enter the queue
   assign fe        = !(f4_vld_ff && q_stat.full);
   assign req_stall = !fe;
   assign q_push    = f4_vld_ff && !q_stat.full;
   assign q_entry   = f4_q_ff;

   assign f1_ex_in = {req_point_x[CoordW-1], req_point_x} - {cfg.start_x[CoordW-1], cfg.start_x};
   assign f1_ey_in = {req_point_y[CoordW-1], req_point_y} - {cfg.start_y[CoordW-1], cfg.start_y};
   assign f1_dx_in = {cfg.end_x[CoordW-1], cfg.end_x} - {cfg.start_x[CoordW-1], cfg.start_x};
   assign f1_dy_in = {cfg.end_y[CoordW-1], cfg.end_y} - {cfg.start_y[CoordW-1], cfg.start_y};

   assign f2_pex_in = $signed(f1_ex_ff) * $signed(f1_dx_ff);
   assign f2_pey_in = $signed(f1_ey_ff) * $signed(f1_dy_ff);
   assign f2_pdx_in = $signed(f1_dx_ff) * $signed(f1_dx_ff);
   assign f2_pdy_in = $signed(f1_dy_ff) * $signed(f1_dy_ff);

   assign f3_dot_in = {f2_pex_ff[ProdW-1], f2_pex_ff} + {f2_pey_ff[ProdW-1], f2_pey_ff};
   // squares stay below 2^64
   assign f3_len_in = {1'b0, f2_pdx_ff[63:0]} + {1'b0, f2_pdy_ff[63:0]};

   assign f4_mx_full = f3_dx_ff[DeltaW-1] ? (~f3_dx_ff + 1'b1) : f3_dx_ff;
   assign f4_my_full = f3_dy_ff[DeltaW-1] ? (~f3_dy_ff + 1'b1) : f3_dy_ff;

   always_comb begin
      f4_q_in      = '0;
      f4_q_in.px   = f3_px_ff;
      f4_q_in.py   = f3_py_ff;
      f4_q_in.best = f3_best_ff;
      f4_q_in.sgnx = f3_dx_ff[DeltaW-1];
      f4_q_in.sgny = f3_dy_ff[DeltaW-1];
      f4_q_in.mx   = f4_mx_full[CoordW-1:0];
      f4_q_in.my   = f4_my_full[CoordW-1:0];
      f4_q_in.dot  = f3_dot_ff[LenW-1:0];
      f4_q_in.len  = f3_len_ff;
      if (f3_len_ff == '0 || f3_dot_ff[DotW-1]) begin
         f4_q_in.sel = SEL_START;
      end else if ({2'b00, f3_len_ff} < f3_dot_ff) begin
         f4_q_in.sel = SEL_END;
      end else begin
         f4_q_in.sel = SEL_FOOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         f4_vld_ff <= 1'b0;
      end else if (fe) begin
         f1_vld_ff <= req_valid;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
         f4_vld_ff <= f3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         f1_px_ff   <= req_point_x;
         f1_py_ff   <= req_point_y;
         f1_best_ff <= req_best_in;
         f1_ex_ff   <= f1_ex_in;
         f1_ey_ff   <= f1_ey_in;
         f1_dx_ff   <= f1_dx_in;
         f1_dy_ff   <= f1_dy_in;
         f2_px_ff   <= f1_px_ff;
         f2_py_ff   <= f1_py_ff;
         f2_best_ff <= f1_best_ff;
         f2_dx_ff   <= f1_dx_ff;
         f2_dy_ff   <= f1_dy_ff;
         f2_pex_ff  <= f2_pex_in;
         f2_pey_ff  <= f2_pey_in;
         f2_pdx_ff  <= f2_pdx_in;
         f2_pdy_ff  <= f2_pdy_in;
         f3_px_ff   <= f2_px_ff;
         f3_py_ff   <= f2_py_ff;
         f3_best_ff <= f2_best_ff;
         f3_dx_ff   <= f2_dx_ff;
         f3_dy_ff   <= f2_dy_ff;
         f3_dot_ff  <= f3_dot_in;
         f3_len_ff  <= f3_len_in;
         f4_q_ff    <= f4_q_in;
      end
   end

endmodule

// ----- hw/rtl/psn_fifo.sv -----
`timescale 1ns / 1ps

module psn_fifo import psn_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_type      push_data,
   input  logic       pop,
   output q_type      pop_data,
   output q_stat_type stat
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   q_type           mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign cnt_in    = cnt_ff + CntW'(push) - CntW'(pop);

   assign stat.full  = (cnt_ff == CntW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/psn_back.sv -----
`timescale 1ns / 1ps

module psn_back import psn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  q_stat_type        q_stat,
   input  q_type             q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_improved,
   output logic [DistW-1:0]  rsp_best_out,
   output logic [CoordW-1:0] rsp_nearest_x,
   output logic [CoordW-1:0] rsp_nearest_y
);

   typedef struct packed {
      logic [CoordW-1:0] px;
      logic [CoordW-1:0] py;
      logic [DistW-1:0]  best;
      sel_type           sel;
      logic              sgnx;
      logic              sgny;
   } meta_type;

   typedef struct packed {
      logic [DistW-1:0]  best;
      logic [CoordW-1:0] nx;
      logic [CoordW-1:0] ny;
   } ctx_type;

   // one restoring step: shift in the next numerator bit, subtract if it fits
   function automatic logic [LenW+QBits-1:0] div_step(input logic [LenW-1:0]  r,
                                                     input logic [QBits-1:0] w,
                                                     input logic [LenW-1:0]  d);
      logic [LenW:0] t;
      logic [LenW:0] diff;
      logic          ge;
      t    = {r, w[QBits-1]};
      diff = t - {1'b0, d};
      ge   = (t >= {1'b0, d});
      return {(ge ? diff[LenW-1:0] : t[LenW-1:0]), w[QBits-2:0], ge};
   endfunction

   localparam int RootW_FIX = RBits;

   logic be;

   // multiply stage
   logic                  m_vld_ff;
   meta_type              m_meta_in, m_meta_ff;
   logic [LenW-1:0]       m_len_ff;
   logic [LenW-1:0]       m_p0x_in, m_p0y_in, m_p0x_ff, m_p0y_ff;
   logic [2*CoordW-1:0]   m_p1x_in, m_p1y_in, m_p1x_ff, m_p1y_ff;

   // divider stages, index = steps done
   logic [NumW-1:0]       nx_in, ny_in;
   logic                  dv_vld_ff  [0:QBits];
   meta_type              dv_meta_ff [0:QBits];
   logic [LenW-1:0]       dv_len_ff  [0:QBits];
   logic [LenW-1:0]       dv_rx_ff   [0:QBits];
   logic [LenW-1:0]       dv_ry_ff   [0:QBits];
   logic [QBits-1:0]      dv_wx_ff   [0:QBits];
   logic [QBits-1:0]      dv_wy_ff   [0:QBits];

   // nearest point, difference, squares
   logic                  sl_vld_ff, df_vld_ff, sq_vld_ff;
   ctx_type               sl_ctx_in, sl_ctx_ff, df_ctx_ff, sq_ctx_ff;
   logic [CoordW-1:0]     sl_px_ff, sl_py_ff;
   logic [DeltaW-1:0]     offx, offy, footx, footy;
   meta_type              dv_last;
   logic [DeltaW-1:0]     df_ddx_in, df_ddy_in, df_ddx_ff, df_ddy_ff;
   logic signed [ProdW-1:0] sq_x_in, sq_y_in;
   logic [63:0]           sq_x_ff, sq_y_ff;

   // root stages, index = bits decided
   logic                  sr_vld_ff  [0:RBits];
   ctx_type               sr_ctx_ff  [0:RBits];
   logic [RemW-1:0]       sr_rem_ff  [0:RBits];
   logic [RootW_FIX-1:0]  sr_root_ff [0:RBits];

   // rounding and result
   logic                  rd_vld_ff;
   ctx_type               rd_ctx_ff;
   logic [DistW-1:0]      rd_dist_in, rd_dist_ff;
   logic                  rsp_vld_ff, rsp_improved_ff, rsp_improved_in;
   logic [DistW-1:0]      rsp_best_ff;
   logic [CoordW-1:0]     rsp_nx_ff, rsp_ny_ff;

   // hold every stage while the result register is stalled
   assign be    = !(rsp_vld_ff && rsp_stall);
   assign q_pop = be && !q_stat.empty;

   assign m_meta_in.px   = q_head.px;
   assign m_meta_in.py   = q_head.py;
   assign m_meta_in.best = q_head.best;
   assign m_meta_in.sel  = q_head.sel;
   assign m_meta_in.sgnx = q_head.sgnx;
   assign m_meta_in.sgny = q_head.sgny;

   assign m_p0x_in = q_head.dot[SplitW-1:0] * q_head.mx;
   assign m_p0y_in = q_head.dot[SplitW-1:0] * q_head.my;
   assign m_p1x_in = q_head.dot[LenW-1:SplitW] * q_head.mx;
   assign m_p1y_in = q_head.dot[LenW-1:SplitW] * q_head.my;

   // numerator = dot * |delta| + len / 2
   assign nx_in = NumW'(m_p0x_ff) + {m_p1x_ff, {SplitW{1'b0}}} + NumW'(m_len_ff[LenW-1:1]);
   assign ny_in = NumW'(m_p0y_ff) + {m_p1y_ff, {SplitW{1'b0}}} + NumW'(m_len_ff[LenW-1:1]);

   always_ff @(posedge clock) begin
      if (be) begin
         m_meta_ff     <= m_meta_in;
         m_len_ff      <= q_head.len;
         m_p0x_ff      <= m_p0x_in;
         m_p0y_ff      <= m_p0y_in;
         m_p1x_ff      <= m_p1x_in;
         m_p1y_ff      <= m_p1y_in;
         dv_meta_ff[0] <= m_meta_ff;
         dv_len_ff[0]  <= m_len_ff;
         dv_rx_ff[0]   <= nx_in[NumW-1:QBits];
         dv_wx_ff[0]   <= nx_in[QBits-1:0];
         dv_ry_ff[0]   <= ny_in[NumW-1:QBits];
         dv_wy_ff[0]   <= ny_in[QBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff     <= 1'b0;
         dv_vld_ff[0] <= 1'b0;
      end else if (be) begin
         m_vld_ff     <= q_pop;
         dv_vld_ff[0] <= m_vld_ff;
      end
   end

   for (genvar j = 1; j <= QBits; j++) begin : g_div
      logic [LenW+QBits-1:0] stx_in, sty_in;

      assign stx_in = div_step(dv_rx_ff[j-1], dv_wx_ff[j-1], dv_len_ff[j-1]);
      assign sty_in = div_step(dv_ry_ff[j-1], dv_wy_ff[j-1], dv_len_ff[j-1]);

      always_ff @(posedge clock) begin
         if (be) begin
            dv_meta_ff[j] <= dv_meta_ff[j-1];
            dv_len_ff[j]  <= dv_len_ff[j-1];
            dv_rx_ff[j]   <= stx_in[LenW+QBits-1:QBits];
            dv_wx_ff[j]   <= stx_in[QBits-1:0];
            dv_ry_ff[j]   <= sty_in[LenW+QBits-1:QBits];
            dv_wy_ff[j]   <= sty_in[QBits-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (be) begin
            dv_vld_ff[j] <= dv_vld_ff[j-1];
         end
      end
   end

   assign dv_last = dv_meta_ff[QBits];
   assign offx  = dv_last.sgnx ? -{1'b0, dv_wx_ff[QBits]} : {1'b0, dv_wx_ff[QBits]};
   assign offy  = dv_last.sgny ? -{1'b0, dv_wy_ff[QBits]} : {1'b0, dv_wy_ff[QBits]};
   assign footx = {cfg.start_x[CoordW-1], cfg.start_x} + offx;
   assign footy = {cfg.start_y[CoordW-1], cfg.start_y} + offy;

   always_comb begin
      sl_ctx_in.best = dv_last.best;
      case (dv_last.sel)
         SEL_END: begin
            sl_ctx_in.nx = cfg.end_x;
            sl_ctx_in.ny = cfg.end_y;
         end
         SEL_FOOT: begin
            sl_ctx_in.nx = footx[CoordW-1:0];
            sl_ctx_in.ny = footy[CoordW-1:0];
         end
         default: begin
            sl_ctx_in.nx = cfg.start_x;
            sl_ctx_in.ny = cfg.start_y;
         end
      endcase
   end

   assign df_ddx_in = {sl_px_ff[CoordW-1], sl_px_ff} - {sl_ctx_ff.nx[CoordW-1], sl_ctx_ff.nx};
   assign df_ddy_in = {sl_py_ff[CoordW-1], sl_py_ff} - {sl_ctx_ff.ny[CoordW-1], sl_ctx_ff.ny};
   assign sq_x_in   = $signed(df_ddx_ff) * $signed(df_ddx_ff);
   assign sq_y_in   = $signed(df_ddy_ff) * $signed(df_ddy_ff);

   always_ff @(posedge clock) begin
      if (be) begin
         sl_ctx_ff     <= sl_ctx_in;
         sl_px_ff      <= dv_last.px;
         sl_py_ff      <= dv_last.py;
         df_ctx_ff     <= sl_ctx_ff;
         df_ddx_ff     <= df_ddx_in;
         df_ddy_ff     <= df_ddy_in;
         sq_ctx_ff     <= df_ctx_ff;
         sq_x_ff       <= sq_x_in[63:0];
         sq_y_ff       <= sq_y_in[63:0];
         sr_ctx_ff[0]  <= sq_ctx_ff;
         sr_rem_ff[0]  <= {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
         sr_root_ff[0] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_vld_ff    <= 1'b0;
         df_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         sr_vld_ff[0] <= 1'b0;
      end else if (be) begin
         sl_vld_ff    <= dv_vld_ff[QBits];
         df_vld_ff    <= sl_vld_ff;
         sq_vld_ff    <= df_vld_ff;
         sr_vld_ff[0] <= sq_vld_ff;
      end
   end

   for (genvar j = 1; j <= RBits; j++) begin : g_root
      localparam int Bit = RBits - j;
      logic [TrialW-1:0] trial;
      logic              ge;

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      assign trial = (TrialW'(sr_root_ff[j-1]) << (Bit + 1)) | (TrialW'(1) << (2 * Bit));
      assign ge    = (TrialW'(sr_rem_ff[j-1]) >= trial);

      always_ff @(posedge clock) begin
         if (be) begin
            sr_ctx_ff[j]  <= sr_ctx_ff[j-1];
            sr_rem_ff[j]  <= ge ? sr_rem_ff[j-1] - trial[RemW-1:0] : sr_rem_ff[j-1];
            sr_root_ff[j] <= ge ? sr_root_ff[j-1] | (RootW_FIX'(1) << Bit) : sr_root_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_vld_ff[j] <= 1'b0;
         end else if (be) begin
            sr_vld_ff[j] <= sr_vld_ff[j-1];
         end
      end
   end

   assign rd_dist_in = (RemW'(sr_root_ff[RBits]) < sr_rem_ff[RBits]) ?
                       DistW'(sr_root_ff[RBits]) + 1'b1 : DistW'(sr_root_ff[RBits]);
   assign rsp_improved_in = (rd_dist_ff < rd_ctx_ff.best);

   always_ff @(posedge clock) begin
      if (be) begin
         rd_ctx_ff       <= sr_ctx_ff[RBits];
         rd_dist_ff      <= rd_dist_in;
         rsp_improved_ff <= rsp_improved_in;
         rsp_best_ff     <= rsp_improved_in ? rd_dist_ff : rd_ctx_ff.best;
         rsp_nx_ff       <= rsp_improved_in ? rd_ctx_ff.nx : '0;
         rsp_ny_ff       <= rsp_improved_in ? rd_ctx_ff.ny : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (be) begin
         rd_vld_ff  <= sr_vld_ff[RBits];
         rsp_vld_ff <= rd_vld_ff;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_improved  = rsp_improved_ff;
   assign rsp_best_out  = rsp_best_ff;
   assign rsp_nearest_x = rsp_nx_ff;
   assign rsp_nearest_y = rsp_ny_ff;

endmodule

// ----- hw/rtl/point_segment_nearest.sv -----
// Throughput: one request per cycle when nothing stalls; the 32-step foot-offset
// divider and 33-step square-root unit are fully pipelined, a stage per quotient/root bit.
// Reset (synchronous, active high) clears all stage valids, the queue and the
// four endpoint registers to zero; in-flight requests are dropped.
`timescale 1ns / 1ps

module point_segment_nearest import psn_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   // configuration write port
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CoordW-1:0] csr_wdata,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CoordW-1:0] req_point_x,
   input  logic [CoordW-1:0] req_point_y,
   input  logic [DistW-1:0]  req_best_in,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_improved,
   output logic [DistW-1:0]  rsp_best_out,
   output logic [CoordW-1:0] rsp_nearest_x,
   output logic [CoordW-1:0] rsp_nearest_y
);

   cfg_type    cfg_ff, cfg_in;
   q_stat_type q_stat;
   q_type      q_entry, q_head;
   logic       q_push, q_pop;

   // Endpoint registers. Change them only while the block is idle; the block
   // does not enforce it. Stages read them directly rather than a carried copy.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_X: cfg_in.start_x = csr_wdata;
            CSR_START_Y: cfg_in.start_y = csr_wdata;
            CSR_END_X:   cfg_in.end_x   = csr_wdata;
            CSR_END_Y:   cfg_in.end_y   = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: differences, dot product and squared length, then classify the
   // projection as before the start, past the end, or on the segment.
   psn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_best_in (req_best_in),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // Short queue: decouples the front stall from the response stall.
   psn_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .pop_data  (q_head),
      .stat      (q_stat)
   );

   // Back: rounded foot offset by long division, nearest point, squared
   // distance, rounded square root, compare against the running best.
   psn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_stat        (q_stat),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_improved  (rsp_improved),
      .rsp_best_out  (rsp_best_out),
      .rsp_nearest_x (rsp_nearest_x),
      .rsp_nearest_y (rsp_nearest_y)
   );

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue push while full");

   // reset leaves no response pending and the front open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pending state after reset");

   // a response without improvement carries no nearest point
   a_no_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_improved) |-> (rsp_nearest_x == '0 && rsp_nearest_y == '0))
      else $error("nearest point on a non-improving response");

endmodule
